@@ rtl/core/pooling_backward_gradient_core_assert.svh @@
// Assertion helpers for the core file pooling_backward_gradient_core.sv.
`ifndef POOLING_BACKWARD_GRADIENT_CORE_ASSERT_SVH
`define POOLING_BACKWARD_GRADIENT_CORE_ASSERT_SVH

// Same-cycle implication.
`define PBG_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("pbg assertion failed");

// Next-cycle implication.
`define PBG_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("pbg assertion failed");

`endif

@@ rtl/core/pbg_pkg.sv @@
`timescale 1ns / 1ps
package pbg_pkg;
  localparam int CMD_BITS = 2;
  localparam int INDEX_BITS = 12;
  localparam int IO_VALUE_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 8;
  // wide enough for any flat index formed from the size registers
  localparam int FLAT_BITS = 21;

  localparam logic [CMD_BITS-1:0] CMD_LOAD_ACT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_GRAD = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RUN = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_READ = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_IN_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_WIDTH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_SIZE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_STRIDE = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_MODE = 3'd7;

  typedef logic [CMD_BITS-1:0] cmd_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic signed [IO_VALUE_BITS-1:0] io_value_t;
endpackage

@@ rtl/core/pbg_req_if.sv @@
`timescale 1ns / 1ps
interface pbg_req_if;
  logic valid;
  logic ready;
  pbg_pkg::cmd_t cmd;
  pbg_pkg::index_t index;
  pbg_pkg::io_value_t value;
  modport source (output valid, cmd, index, value, input ready);
  modport sink (input valid, cmd, index, value, output ready);
endinterface

@@ rtl/core/pbg_rsp_if.sv @@
`timescale 1ns / 1ps
interface pbg_rsp_if;
  logic valid;
  logic ready;
  pbg_pkg::io_value_t grad_value;
  modport source (output valid, grad_value, input ready);
  modport sink (input valid, grad_value, output ready);
endinterface

@@ rtl/core/pbg_cfg_if.sv @@
`timescale 1ns / 1ps
interface pbg_cfg_if;
  logic valid;
  logic ready;
  logic [pbg_pkg::CFG_IDX_BITS-1:0] index;
  logic [pbg_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pbg_ram.sv @@
`timescale 1ns / 1ps
module pbg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/pooling_backward_gradient_core.sv @@
`timescale 1ns / 1ps
// channel  dir  beat
// cfg      in   index, data: one size/mode register write
// req      in   cmd, index, value: load activation, load gradient, run, read
// rsp      out  grad_value: input gradient for a read
// Loads write on acceptance; reads pass the store read port and out_data.
// A run clears the gradient store, then for each output position steps S_POS,
// S_GRAD, the serial divider in average mode, then per window element S_EADDR,
// S_EREAD, S_EUSE (skipped when it falls outside the map) and S_ENEXT, then
// S_MREAD/S_MWRITE in max mode if found, and S_PNEXT; req is not ready meanwhile.
// Reset runs the same clearing pass before req goes ready.
// A pending rsp beat holds req off until it can drain.
`include "pooling_backward_gradient_core_assert.svh"
module pooling_backward_gradient_core #(
  parameter int MAP_ENTRIES = 4096,
  parameter int VALUE_BITS = 16,
  parameter int MAX_WINDOW = 4
) (
  input logic clk,
  input logic rst,
  pbg_cfg_if.sink cfg,
  pbg_req_if.sink req,
  pbg_rsp_if.source rsp
);
  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int OCW = $clog2(MAP_ENTRIES + 1);
  localparam int VB = VALUE_BITS;
  localparam int PW = $clog2(MAX_WINDOW + 1);
  localparam int DW = 2 * PW;
  localparam int SCW = $clog2(VB + 1);
  localparam int ROWW = 11;
  localparam int FW = pbg_pkg::FLAT_BITS;
  localparam logic signed [33:0] VHI = (34'sd1 <<< (VB - 1)) - 34'sd1;
  localparam logic signed [33:0] VLO = -VHI - 34'sd1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_ENTRIES - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_POS = 4'd2;
  localparam logic [3:0] S_GRAD = 4'd3;
  localparam logic [3:0] S_DIV = 4'd4;
  localparam logic [3:0] S_EADDR = 4'd5;
  localparam logic [3:0] S_EREAD = 4'd6;
  localparam logic [3:0] S_EUSE = 4'd7;
  localparam logic [3:0] S_ENEXT = 4'd8;
  localparam logic [3:0] S_MREAD = 4'd9;
  localparam logic [3:0] S_MWRITE = 4'd10;
  localparam logic [3:0] S_PNEXT = 4'd11;

  function automatic logic signed [VB-1:0] sat_vb(input logic signed [33:0] x);
    logic signed [VB-1:0] r;
    if (x > VHI) r = VHI[VB-1:0];
    else if (x < VLO) r = VLO[VB-1:0];
    else r = x[VB-1:0];
    return r;
  endfunction

  // configuration registers
  logic [6:0] in_width, in_height, out_width, out_height;
  logic [4:0] channels;
  logic [2:0] pool_size, pool_stride;
  logic pool_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width <= 7'd1;
      in_height <= 7'd1;
      channels <= 5'd1;
      out_width <= 7'd1;
      out_height <= 7'd1;
      pool_size <= 3'd2;
      pool_stride <= 3'd2;
      pool_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pbg_pkg::REG_IN_WIDTH: in_width <= cfg.data[6:0];
        pbg_pkg::REG_IN_HEIGHT: in_height <= cfg.data[6:0];
        pbg_pkg::REG_CHANNELS: channels <= cfg.data[4:0];
        pbg_pkg::REG_OUT_WIDTH: out_width <= cfg.data[6:0];
        pbg_pkg::REG_OUT_HEIGHT: out_height <= cfg.data[6:0];
        pbg_pkg::REG_POOL_SIZE: pool_size <= cfg.data[2:0];
        pbg_pkg::REG_POOL_STRIDE: pool_stride <= cfg.data[2:0];
        pbg_pkg::REG_POOL_MODE: pool_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [3:0] state;
  logic run_go;
  logic [AW-1:0] clr_addr;
  logic [4:0] ch;
  logic [6:0] oh, ow;
  logic [OCW-1:0] oidx;
  logic [ROWW-1:0] row_base, col_base;
  logic [11:0] chan_row;
  logic [PW-1:0] ph, pw;
  logic signed [VB-1:0] grad, part, best;
  logic found;
  logic [AW-1:0] best_idx, eidx;
  logic einb;
  logic [VB-1:0] quo;
  logic [DW-1:0] rem;
  logic [SCW-1:0] step;
  logic neg;
  logic pend, pend_ok;
  logic out_valid;
  logic signed [VB-1:0] out_data;

  logic [PW-1:0] p_eff;
  assign p_eff = (32'(pool_size) > MAX_WINDOW) ? PW'(MAX_WINDOW) : PW'(pool_size);
  logic [DW-1:0] divisor;
  assign divisor = DW'(p_eff) * DW'(p_eff);

  logic req_ok, accept;
  assign req_ok = 32'(req.index) < MAP_ENTRIES;
  assign req.ready = (state == S_IDLE) && !pend && (!out_valid || rsp.ready);
  assign accept = req.valid && req.ready;

  // memories
  logic act_we, og_we, ig_we;
  logic [AW-1:0] ig_waddr, ig_raddr;
  logic [VB-1:0] ig_wdata, act_rdata, og_rdata, ig_rdata;
  logic signed [VB-1:0] load_val;
  assign load_val = sat_vb(34'(req.value));
  assign act_we = accept && req.cmd == pbg_pkg::CMD_LOAD_ACT && req_ok;
  assign og_we = accept && req.cmd == pbg_pkg::CMD_LOAD_GRAD && req_ok;

  pbg_ram #(.WIDTH(VB), .DEPTH(MAP_ENTRIES)) u_act (
    .clk(clk), .we(act_we), .waddr(AW'(req.index)), .wdata(load_val),
    .raddr(eidx), .rdata(act_rdata)
  );
  pbg_ram #(.WIDTH(VB), .DEPTH(MAP_ENTRIES)) u_og (
    .clk(clk), .we(og_we), .waddr(AW'(req.index)), .wdata(load_val),
    .raddr(oidx[AW-1:0]), .rdata(og_rdata)
  );
  pbg_ram #(.WIDTH(VB), .DEPTH(MAP_ENTRIES)) u_ig (
    .clk(clk), .we(ig_we), .waddr(ig_waddr), .wdata(ig_wdata),
    .raddr(ig_raddr), .rdata(ig_rdata)
  );

  logic signed [VB-1:0] acc_add;
  assign acc_add = (state == S_MWRITE) ? grad : part;

  always_comb begin
    ig_we = 1'b0;
    ig_waddr = clr_addr;
    ig_wdata = '0;
    ig_raddr = AW'(req.index);
    case (state)
      S_CLEAR: ig_we = 1'b1;
      S_EREAD: ig_raddr = eidx;
      S_EUSE: begin
        ig_we = pool_mode;
        ig_waddr = eidx;
        ig_wdata = sat_vb(34'(signed'(ig_rdata)) + 34'(acc_add));
      end
      S_MREAD: ig_raddr = best_idx;
      S_MWRITE: begin
        ig_we = 1'b1;
        ig_waddr = best_idx;
        ig_wdata = sat_vb(34'(signed'(ig_rdata)) + 34'(acc_add));
      end
      default: ;
    endcase
  end

  // window element address
  logic [ROWW-1:0] ih, iw;
  logic [FW-1:0] iidx;
  assign ih = row_base + ROWW'(ph);
  assign iw = col_base + ROWW'(pw);
  assign iidx = (FW'(chan_row) + FW'(ih)) * FW'(in_width) + FW'(iw);

  logic pw_last, ph_last;
  assign pw_last = ({1'b0, pw} + 1'b1) == {1'b0, p_eff};
  assign ph_last = ({1'b0, ph} + 1'b1) == {1'b0, p_eff};

  logic [DW:0] dsh;
  assign dsh = {rem, quo[VB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      run_go <= 1'b0;
      clr_addr <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      if (pend) begin
        pend <= 1'b0;
        out_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept && req.cmd == pbg_pkg::CMD_READ) begin
            pend <= 1'b1;
            pend_ok <= req_ok;
          end
          if (accept && req.cmd == pbg_pkg::CMD_RUN) begin
            run_go <= 1'b1;
            clr_addr <= '0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            run_go <= 1'b0;
            if (!run_go || p_eff == '0 || channels == '0 || out_width == '0 ||
                out_height == '0) begin
              state <= S_IDLE;
            end else begin
              ch <= '0;
              oh <= '0;
              ow <= '0;
              oidx <= '0;
              row_base <= '0;
              col_base <= '0;
              chan_row <= '0;
              state <= S_POS;
            end
          end
        end
        S_POS: begin
          // positions beyond the store end the walk: later ones are larger
          if (oidx == OCW'(MAP_ENTRIES)) state <= S_IDLE;
          else state <= S_GRAD;
        end
        S_GRAD: begin
          grad <= og_rdata;
          found <= 1'b0;
          ph <= '0;
          pw <= '0;
          neg <= og_rdata[VB-1];
          quo <= og_rdata[VB-1] ? VB'(-og_rdata) : og_rdata;
          rem <= '0;
          step <= '0;
          state <= pool_mode ? S_DIV : S_EADDR;
        end
        S_DIV: begin
          if (step == SCW'(VB)) begin
            part <= neg ? -quo : quo;
            state <= S_EADDR;
          end else begin
            step <= step + 1'b1;
            if (dsh >= {1'b0, divisor}) begin
              rem <= DW'(dsh - {1'b0, divisor});
              quo <= {quo[VB-2:0], 1'b1};
            end else begin
              rem <= dsh[DW-1:0];
              quo <= {quo[VB-2:0], 1'b0};
            end
          end
        end
        S_EADDR: begin
          eidx <= AW'(iidx);
          einb <= ih < ROWW'(in_height) && iw < ROWW'(in_width) &&
                  iidx < FW'(MAP_ENTRIES);
          state <= S_EREAD;
        end
        S_EREAD: state <= einb ? S_EUSE : S_ENEXT;
        S_EUSE: begin
          if (!pool_mode && (!found || signed'(act_rdata) > best)) begin
            found <= 1'b1;
            best <= act_rdata;
            best_idx <= eidx;
          end
          state <= S_ENEXT;
        end
        S_ENEXT: begin
          if (!pw_last) begin
            pw <= pw + 1'b1;
            state <= S_EADDR;
          end else if (!ph_last) begin
            pw <= '0;
            ph <= ph + 1'b1;
            state <= S_EADDR;
          end else begin
            state <= (!pool_mode && found) ? S_MREAD : S_PNEXT;
          end
        end
        S_MREAD: state <= S_MWRITE;
        S_MWRITE: state <= S_PNEXT;
        S_PNEXT: begin
          oidx <= oidx + 1'b1;
          state <= S_POS;
          if (({1'b0, ow} + 1'b1) < {1'b0, out_width}) begin
            ow <= ow + 1'b1;
            col_base <= col_base + ROWW'(pool_stride);
          end else begin
            ow <= '0;
            col_base <= '0;
            if (({1'b0, oh} + 1'b1) < {1'b0, out_height}) begin
              oh <= oh + 1'b1;
              row_base <= row_base + ROWW'(pool_stride);
            end else begin
              oh <= '0;
              row_base <= '0;
              if (({1'b0, ch} + 1'b1) < {1'b0, channels}) begin
                ch <= ch + 1'b1;
                chan_row <= chan_row + 12'(in_height);
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read result is registered in the store read port, then in out_data
  logic signed [15:0] rd_sat;
  always_comb begin
    if (34'(signed'(ig_rdata)) > 34'sd32767) rd_sat = 16'sh7fff;
    else if (34'(signed'(ig_rdata)) < -34'sd32768) rd_sat = -16'sh8000;
    else rd_sat = 16'(signed'(ig_rdata));
  end

  always_ff @(posedge clk) begin
    if (pend) out_data <= pend_ok ? VB'(rd_sat) : '0;
  end

  assign rsp.valid = out_valid;
  assign rsp.grad_value = 16'(out_data);

  `PBG_ASSERT_IMP(a_req_idle, clk, rst, req.valid && req.ready, state == S_IDLE)
  `PBG_ASSERT_NXT(a_pend_out, clk, rst, pend, rsp.valid)
  `PBG_ASSERT_NXT(a_clear_end, clk, rst, state == S_CLEAR && clr_addr == CLR_LAST,
                  state != S_CLEAR)
  `PBG_ASSERT_IMP(a_max_found, clk, rst, state == S_MWRITE, found && !pool_mode)
endmodule
